// File: rtl/core/nfc_pkg.sv
// Shared types and constants for the NMEA field capture block.
package nfc_pkg;

	localparam int CAPTURE_LEN_DEF = 16;
	localparam int SLOT_COUNT      = 2;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PADDR_W         = 4;

	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_COMMA = 8'h2c;

	localparam logic [1:0] KIND_GGA = 2'd1;
	localparam logic [1:0] KIND_RMC = 2'd2;
	localparam logic [4:0] FIELD_MAX = 5'd31;

	// register indexes
	localparam logic [1:0] REG_SLOT0_SENTENCE = 2'd0;
	localparam logic [1:0] REG_SLOT0_FIELD    = 2'd1;
	localparam logic [1:0] REG_SLOT1_SENTENCE = 2'd2;
	localparam logic [1:0] REG_SLOT1_FIELD    = 2'd3;

	// one accepted byte that hit at least one slot
	typedef struct packed {
		logic [7:0]                  ch;
		logic [SLOT_COUNT-1:0]       hit;
		logic [SLOT_COUNT-1:0][3:0]  pos;
	} nfc_entry_t;

	// queue status seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} nfc_qstat_t;

endpackage

// File: rtl/core/nfc_in_if.sv
// Input byte channel: received character with line error flag.
interface nfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       line_error;

	modport source (output valid, output rx_byte, output line_error, input ready);
	modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

// File: rtl/core/nfc_out_if.sv
// Output channel: one character write event per request.
interface nfc_out_if;
	logic       valid;
	logic       ready;
	logic       slot_index;
	logic [3:0] char_position;
	logic [7:0] char_value;
	logic       last_event;

	modport source (output valid, output slot_index, output char_position,
		output char_value, output last_event, input ready);
	modport sink   (input valid, input slot_index, input char_position,
		input char_value, input last_event, output ready);
endinterface

// File: rtl/core/nmea_field_capture.sv
// Top level of the NMEA 0183 sentence field capture block.
//
// in_ch takes one received UART byte per request with its line error flag.
// The parser syncs on GGA or RMC followed by a comma and counts fields up
// to '*'. Each of the first CAPTURE_LEN-1 bytes of a field selected by a
// capture slot gives one write request on out_ch per matching slot (slot 0
// first), last_event marking the final request of that byte.
// Throughput: one input byte per cycle while the queue is not full; out_ch
// drains one request per cycle while ready is high, so a byte hitting both
// slots needs two output requests; events reach out_ch through the queue.
// A four-entry queue decouples the parser from the output side: when the
// receiver stalls, bytes are still taken until the queue fills, then in_ch
// ready drops. Bytes that hit no slot never occupy the queue.
// The APB port holds each slot's sentence kind and field number; writing a
// new selection rearms that slot, clears its fill and resyncs the parser.
// A line error disarms every slot and resyncs.
// Reset clears the parser, all selections, fills and armed flags and empties
// the queue; no clearing pass is needed.
module nmea_field_capture
	import nfc_pkg::*;
#(
	parameter int CAPTURE_LEN = CAPTURE_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	nfc_in_if.sink             in_ch,
	nfc_out_if.source          out_ch
);

	nfc_entry_t push_entry;
	nfc_entry_t head;
	nfc_qstat_t qstat;
	logic       push;
	logic       pop;

	// zero wait state register port
	assign pready = 1'b1;

	nfc_front #(
		.CAPTURE_LEN(CAPTURE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.in_ch     (in_ch),
		.qstat     (qstat),
		.push      (push),
		.push_entry(push_entry)
	);

	nfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	nfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// File: rtl/core/nfc_front.sv
// Front end: register port, sentence parser and slot match.
module nfc_front
	import nfc_pkg::*;
#(
	parameter int CAPTURE_LEN = CAPTURE_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	nfc_in_if.sink             in_ch,
	input  nfc_qstat_t         qstat,
	output logic               push,
	output nfc_entry_t         push_entry
);

	localparam int FW = $clog2(CAPTURE_LEN);

	localparam logic [2:0] PH_WAIT_TAG   = 3'd0;
	localparam logic [2:0] PH_GOT_G      = 3'd1;
	localparam logic [2:0] PH_GOT_GG     = 3'd2;
	localparam logic [2:0] PH_GOT_R      = 3'd3;
	localparam logic [2:0] PH_GOT_RM     = 3'd4;
	localparam logic [2:0] PH_WAIT_COMMA = 3'd5;
	localparam logic [2:0] PH_READ_FIELD = 3'd6;

	logic [2:0]    phase_q;
	logic [1:0]    kind_q;
	logic [4:0]    field_q;
	logic [FW-1:0] fill_q   [SLOT_COUNT];
	logic          armed_q  [SLOT_COUNT];
	logic [1:0]    sel_sent_q  [SLOT_COUNT];
	logic [4:0]    sel_field_q [SLOT_COUNT];

	logic          accept;
	logic          wr;
	logic [1:0]    widx;
	logic          wslot;
	logic          wchanged;
	logic          is_data;
	logic [SLOT_COUNT-1:0] hit;

	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	assign wr    = psel && penable && pwrite;
	assign widx  = paddr[3:2];
	assign wslot = widx[1];

	always_comb begin
		case (widx)
			REG_SLOT0_SENTENCE: prdata = {30'd0, sel_sent_q[0]};
			REG_SLOT0_FIELD:    prdata = {27'd0, sel_field_q[0]};
			REG_SLOT1_SENTENCE: prdata = {30'd0, sel_sent_q[1]};
			REG_SLOT1_FIELD:    prdata = {27'd0, sel_field_q[1]};
			default:            prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (widx[0]) begin
			wchanged = !armed_q[wslot] || (sel_field_q[wslot] != pwdata[4:0]);
		end else begin
			wchanged = !armed_q[wslot] || (sel_sent_q[wslot] != pwdata[1:0]);
		end
	end

	// character byte inside a field
	assign is_data = (phase_q == PH_READ_FIELD) && !in_ch.line_error &&
		(in_ch.rx_byte != CH_STAR) && (in_ch.rx_byte != CH_COMMA);

	always_comb begin
		logic [FW+3:0] ext;
		push_entry.ch = in_ch.rx_byte;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			ext = {4'd0, fill_q[s]};
			hit[s] = armed_q[s] && (sel_sent_q[s] == kind_q) &&
				(sel_field_q[s] == field_q) && (fill_q[s] < FW'(CAPTURE_LEN - 1));
			push_entry.hit[s] = hit[s];
			push_entry.pos[s] = ext[3:0];
		end
	end

	assign push = accept && is_data && (|hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_TAG;
			kind_q  <= 2'd0;
			field_q <= 5'd0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				fill_q[s]      <= '0;
				armed_q[s]     <= 1'b0;
				sel_sent_q[s]  <= 2'd0;
				sel_field_q[s] <= 5'd0;
			end
		end else begin
			if (accept) begin
				if (in_ch.line_error) begin
					phase_q <= PH_WAIT_TAG;
					for (int s = 0; s < SLOT_COUNT; s++) begin
						armed_q[s] <= 1'b0;
					end
				end else begin
					case (phase_q)
						PH_GOT_G: begin
							phase_q <= (in_ch.rx_byte == CH_G) ? PH_GOT_GG : PH_WAIT_TAG;
						end
						PH_GOT_R: begin
							phase_q <= (in_ch.rx_byte == CH_M) ? PH_GOT_RM : PH_WAIT_TAG;
						end
						PH_GOT_GG, PH_GOT_RM: begin
							if ((phase_q == PH_GOT_GG && in_ch.rx_byte == CH_A) ||
								(phase_q == PH_GOT_RM && in_ch.rx_byte == CH_C)) begin
								phase_q <= PH_WAIT_COMMA;
								kind_q  <= (phase_q == PH_GOT_GG) ? KIND_GGA : KIND_RMC;
								field_q <= 5'd1;
								for (int s = 0; s < SLOT_COUNT; s++) begin
									fill_q[s] <= '0;
								end
							end else begin
								phase_q <= PH_WAIT_TAG;
							end
						end
						PH_WAIT_COMMA: begin
							if (in_ch.rx_byte == CH_COMMA) begin
								phase_q <= PH_READ_FIELD;
								field_q <= 5'd1;
								for (int s = 0; s < SLOT_COUNT; s++) begin
									fill_q[s] <= '0;
								end
							end else begin
								phase_q <= PH_WAIT_TAG;
							end
						end
						PH_READ_FIELD: begin
							if (in_ch.rx_byte == CH_STAR) begin
								phase_q <= PH_WAIT_TAG;
							end else if (in_ch.rx_byte == CH_COMMA) begin
								if (field_q < FIELD_MAX) begin
									field_q <= field_q + 5'd1;
								end
							end else begin
								for (int s = 0; s < SLOT_COUNT; s++) begin
									if (hit[s]) begin
										fill_q[s] <= fill_q[s] + FW'(1);
									end
								end
							end
						end
						default: begin
							if (in_ch.rx_byte == CH_G) begin
								phase_q <= PH_GOT_G;
							end else if (in_ch.rx_byte == CH_R) begin
								phase_q <= PH_GOT_R;
							end else begin
								phase_q <= PH_WAIT_TAG;
							end
						end
					endcase
				end
			end
			// selection write: rearm, clear and resync
			if (wr && wchanged) begin
				if (widx[0]) begin
					sel_field_q[wslot] <= pwdata[4:0];
				end else begin
					sel_sent_q[wslot] <= pwdata[1:0];
				end
				armed_q[wslot] <= 1'b1;
				fill_q[wslot]  <= '0;
				phase_q        <= PH_WAIT_TAG;
			end
		end
	end

endmodule

// File: rtl/core/nfc_queue.sv
// Short FIFO of hit entries between parser and event serializer.
module nfc_queue
	import nfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  nfc_entry_t push_entry,
	input  logic       pop,
	output nfc_entry_t head,
	output nfc_qstat_t qstat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	nfc_entry_t  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   count_q;

	assign qstat.full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/nfc_back.sv
// Back end: splits each queued entry into per-slot write events.
module nfc_back
	import nfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  nfc_entry_t head,
	input  nfc_qstat_t qstat,
	output logic       pop,
	nfc_out_if.source  out_ch
);

	logic [SLOT_COUNT-1:0] sent_q;
	logic [SLOT_COUNT-1:0] pending;
	logic                  take;

	assign pending = head.hit & ~sent_q;

	assign out_ch.valid         = !qstat.empty;
	assign out_ch.slot_index    = !pending[0];
	assign out_ch.char_position = pending[0] ? head.pos[0] : head.pos[1];
	assign out_ch.char_value    = head.ch;
	assign out_ch.last_event    = !(pending[0] && pending[1]);

	assign take = out_ch.valid && out_ch.ready;
	assign pop  = take && out_ch.last_event;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
		end else if (take) begin
			if (out_ch.last_event) begin
				sent_q <= '0;
			end else begin
				sent_q[0] <= 1'b1;
			end
		end
	end

endmodule
